// ===== src/ssdfb_pkg.sv =====
// Shared types, constants and helper functions of the display frame builder.
`timescale 1ns / 1ps
`default_nettype none
package ssdfb_pkg;

  // Request queue between the digit front end and the byte emitter.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the configuration port.
  localparam logic REG_DATA_MODE = 1'b0;
  localparam logic REG_DISP_CTRL = 1'b1;

  localparam logic [7:0] DATA_MODE_RESET = 8'h40;
  localparam logic [7:0] DISP_CTRL_RESET = 8'h88;

  // Display kinds.
  localparam logic [2:0] KIND_TEMP  = 3'd1;
  localparam logic [2:0] KIND_HUMID = 3'd2;
  localparam logic [2:0] KIND_LIGHT = 3'd3;
  localparam logic [2:0] KIND_PLAIN = 3'd4;

  // Segment table indexes.
  localparam logic [6:0] IDX_BLANK  = 7'd10;
  localparam logic [6:0] IDX_C      = 7'd11;
  localparam logic [6:0] IDX_H      = 7'd12;
  localparam logic [6:0] TABLE_SIZE = 7'd14;

  localparam logic [15:0] THRESH_FOUR = 16'd1000;
  localparam logic [15:0] THRESH_TWO  = 16'd9;

  // Reciprocal of ten, exact for any 16-bit dividend.
  localparam logic [32:0] RECIP10 = 33'd52429;

  typedef struct packed {
    logic [7:0]       addr;
    logic [3:0][7:0]  seg;
    logic [3:0]       ovf;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] mode_cmd;
    logic [7:0] ctrl_cmd;
  } cfg_t;

  typedef struct packed {
    logic       strobe;
    logic [7:0] data;
    logic       frame_begin;
    logic       frame_end;
    logic       overflow;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MODE,
    PH_ADDR,
    PH_SEG0,
    PH_SEG1,
    PH_SEG2,
    PH_SEG3,
    PH_CTRL
  } phase_t;

  // x / 10 by reciprocal multiply.
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * RECIP10;
    return p[31:19];
  endfunction

  // x - 10*q, the low decimal digit.
  function automatic logic [3:0] rem10(input logic [15:0] x, input logic [12:0] q);
    logic [15:0] t;
    t = x - 16'({3'd0, q} * 16'd10);
    return t[3:0];
  endfunction

  function automatic logic [7:0] seg_pattern(input logic [6:0] idx);
    logic [7:0] pat;
    unique case (idx)
      7'd0:    pat = 8'h3f;
      7'd1:    pat = 8'h06;
      7'd2:    pat = 8'h5b;
      7'd3:    pat = 8'h4f;
      7'd4:    pat = 8'h66;
      7'd5:    pat = 8'h6d;
      7'd6:    pat = 8'h7d;
      7'd7:    pat = 8'h07;
      7'd8:    pat = 8'h7f;
      7'd9:    pat = 8'h6f;
      7'd11:   pat = 8'h39;
      7'd12:   pat = 8'h76;
      7'd13:   pat = 8'h80;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ===== src/ssdfb_front.sv =====
// Front end: splits the value into decimal digits and forms the segment bytes.
`timescale 1ns / 1ps
`default_nettype none
module ssdfb_front import ssdfb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  addr,
  input  wire logic [15:0] value,
  input  wire logic [2:0]  kind,
  output logic             push,
  output q_entry_t         entry
);

  // stage 1: v / 10
  logic        vld1, vld2, vld3;
  logic [7:0]  addr1, addr2, addr3;
  logic [2:0]  kind1, kind2, kind3;
  logic        gt4_1, gt4_2, gt4_3;
  logic        gt2_1, gt2_2, gt2_3;
  logic [15:0] v1;
  logic [12:0] q1_1, q1_2, q1_3;
  // stage 2: v / 100, v % 10
  logic [3:0]  r0_2, r0_3;
  logic [9:0]  q2_2, q2_3;
  // stage 3: v / 1000, (v / 10) % 10
  logic [3:0]  r1_3;
  logic [6:0]  q3_3;

  logic [12:0] q2_full, q3_full;
  logic [3:0]  r2;
  logic [6:0]  d [4];

  assign q2_full = div10({3'd0, q1_1});
  assign q3_full = div10({6'd0, q2_2});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      vld1 <= take;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    addr1 <= addr;
    kind1 <= kind;
    gt4_1 <= value > THRESH_FOUR;
    gt2_1 <= value > THRESH_TWO;
    v1    <= value;
    q1_1  <= div10(value);

    addr2 <= addr1;
    kind2 <= kind1;
    gt4_2 <= gt4_1;
    gt2_2 <= gt2_1;
    q1_2  <= q1_1;
    r0_2  <= rem10(v1, q1_1);
    q2_2  <= q2_full[9:0];

    addr3 <= addr2;
    kind3 <= kind2;
    gt4_3 <= gt4_2;
    gt2_3 <= gt2_2;
    q1_3  <= q1_2;
    r0_3  <= r0_2;
    q2_3  <= q2_2;
    r1_3  <= rem10({3'd0, q1_2}, {3'd0, q2_2});
    q3_3  <= q3_full[6:0];
  end

  assign r2 = rem10({6'd0, q2_3}, {6'd0, q3_3});

  always_comb begin
    priority if (gt4_3) begin
      d[0] = q3_3;
      d[1] = {3'd0, r2};
      d[2] = {3'd0, r1_3};
    end else if (gt2_3) begin
      d[0] = q1_3[6:0];
      d[1] = {3'd0, r0_3};
      d[2] = IDX_BLANK;
    end else begin
      d[0] = 7'd0;
      d[1] = {3'd0, r0_3};
      d[2] = IDX_BLANK;
    end
    unique case (kind3)
      KIND_TEMP:              d[3] = IDX_C;
      KIND_HUMID:             d[3] = IDX_H;
      KIND_LIGHT, KIND_PLAIN: d[3] = {3'd0, r0_3};
      default:                d[3] = IDX_BLANK;
    endcase
  end

  always_comb begin
    entry.addr = addr3;
    for (int i = 0; i < 4; i++) begin
      entry.seg[i] = seg_pattern(d[i]);
      entry.ovf[i] = d[i] >= TABLE_SIZE;
    end
  end

  assign push = vld3;

endmodule
`default_nettype wire

// ===== src/ssdfb_queue.sv =====
// Small FIFO of decoded updates between the front end and the emitter.
`timescale 1ns / 1ps
`default_nettype none
module ssdfb_queue import ssdfb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t din,
  input  wire logic     pop,
  output q_entry_t      dout,
  output logic          empty,
  output logic          full
);

  q_entry_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  assign dout  = mem[rd_ptr];
  assign empty = count == '0;
  assign full  = count == QCNT_W'(QUEUE_DEPTH);

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");

endmodule
`default_nettype wire

// ===== src/ssdfb_back.sv =====
// Byte emitter: walks one queued update through its seven words.
`timescale 1ns / 1ps
`default_nettype none
module ssdfb_back import ssdfb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire q_entry_t head,
  input  wire logic     empty,
  output logic          pop,
  output res_t          res
);

  phase_t   state, state_next;
  q_entry_t cur;

  assign pop = ((state == PH_IDLE) || (state == PH_CTRL)) && !empty;

  always_comb begin
    unique case (state)
      PH_IDLE: state_next = pop ? PH_MODE : PH_IDLE;
      PH_MODE: state_next = PH_ADDR;
      PH_ADDR: state_next = PH_SEG0;
      PH_SEG0: state_next = PH_SEG1;
      PH_SEG1: state_next = PH_SEG2;
      PH_SEG2: state_next = PH_SEG3;
      PH_SEG3: state_next = PH_CTRL;
      PH_CTRL: state_next = pop ? PH_MODE : PH_IDLE;
      default: state_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= PH_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_comb begin
    res = '0;
    unique case (state)
      PH_IDLE: res = '0;
      PH_MODE: begin
        res.strobe      = 1'b1;
        res.data        = cfg.mode_cmd;
        res.frame_begin = 1'b1;
        res.frame_end   = 1'b1;
      end
      PH_ADDR: begin
        res.strobe      = 1'b1;
        res.data        = cur.addr;
        res.frame_begin = 1'b1;
      end
      PH_SEG0: begin
        res.strobe   = 1'b1;
        res.data     = cur.seg[0];
        res.overflow = cur.ovf[0];
      end
      PH_SEG1: begin
        res.strobe   = 1'b1;
        res.data     = cur.seg[1];
        res.overflow = cur.ovf[1];
      end
      PH_SEG2: begin
        res.strobe   = 1'b1;
        res.data     = cur.seg[2];
        res.overflow = cur.ovf[2];
      end
      PH_SEG3: begin
        res.strobe    = 1'b1;
        res.data      = cur.seg[3];
        res.overflow  = cur.ovf[3];
        res.frame_end = 1'b1;
      end
      PH_CTRL: begin
        res.strobe      = 1'b1;
        res.data        = cfg.ctrl_cmd;
        res.frame_begin = 1'b1;
        res.frame_end   = 1'b1;
        res.last        = 1'b1;
      end
      default: res = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/seven_segment_display_frame_builder.sv =====
// Top level of the seven-segment display frame builder.
`timescale 1ns / 1ps
`default_nettype none
// Each request (start_address, shown_value, display_kind) taken on start while
// busy is low turns into one display update of seven words, one per clock:
// the data-mode command (own frame), the start address and four segment
// bytes (one frame), and the display-control command (own frame, last_byte
// set). frame_begin marks a start condition before a word, frame_end a stop
// condition after it. A word is valid only in the cycle that strobe is high;
// the receiver cannot stall, so every word must be taken when it appears.
// Sustained rate is set by the emitter, which sends one word per cycle;
// requests follow back to back with no gap words. A request's first word
// appears once it has passed the digit extraction stages (one divide-by-ten
// multiply per stage), the request queue and the emitter's phase register.
// Up to four requests may be in flight; busy is high while all four slots
// are taken.
// The two command registers sit on the APB port at 0x0 (data mode, reset
// 0x40) and 0x4 (display control, reset 0x88); write them only while idle.
module seven_segment_display_frame_builder import ssdfb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // request
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  start_address,
  input  wire logic [15:0] shown_value,
  input  wire logic [2:0]  display_kind,
  // result words
  output logic             strobe,
  output logic [7:0]       out_byte,
  output logic             frame_begin,
  output logic             frame_end,
  output logic             digit_overflow,
  output logic             last_byte,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t              cfg;
  logic              take;
  logic              push, pop, q_empty, q_full;
  q_entry_t          entry, head;
  res_t              res;
  logic [QCNT_W-1:0] inflight;
  logic              reg_sel;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];   // low address bits are don't care

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_cmd <= DATA_MODE_RESET;
      cfg.ctrl_cmd <= DISP_CTRL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_DATA_MODE: cfg.mode_cmd <= pwdata[7:0];
        REG_DISP_CTRL: cfg.ctrl_cmd <= pwdata[7:0];
        default:       cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DATA_MODE: prdata = {24'd0, cfg.mode_cmd};
      REG_DISP_CTRL: prdata = {24'd0, cfg.ctrl_cmd};
      default:       prdata = '0;
    endcase
  end

  // ---------------- request intake and slot accounting ----------------
  // inflight counts requests taken but not yet popped by the emitter; capping
  // it at the queue depth guarantees the front end never finds the queue full.
  assign take = start && !busy;
  assign busy = inflight == QCNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      unique case ({take, pop})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  ssdfb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .addr  (start_address),
    .value (shown_value),
    .kind  (display_kind),
    .push  (push),
    .entry (entry)
  );

  ssdfb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  ssdfb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .empty (q_empty),
    .pop   (pop),
    .res   (res)
  );

  // ---------------- result word ----------------
  assign strobe         = res.strobe;
  assign out_byte       = res.data;
  assign frame_begin    = res.frame_begin;
  assign frame_end      = res.frame_end;
  assign digit_overflow = res.overflow;
  assign last_byte      = res.last;

  // slot count never exceeds queue depth
  a_inflight_cap: assert property (@(posedge clk) disable iff (rst)
      inflight <= QCNT_W'(QUEUE_DEPTH))
    else $error("more requests in flight than queue slots");
  // a full queue implies every slot is accounted as in flight
  a_full_busy: assert property (@(posedge clk) disable iff (rst) q_full |-> busy)
    else $error("queue full while intake open");
  // the address word always directly follows the one-word command frame
  a_addr_after_cmd: assert property (@(posedge clk) disable iff (rst)
      (strobe && frame_begin && !frame_end) |->
        $past(strobe && frame_begin && frame_end && !last_byte))
    else $error("address word without preceding data-mode word");

endmodule
`default_nettype wire

// ===== tb/seven_segment_display_frame_builder_checker.sv =====
// Checker for the display frame builder: predicts each update's words and compares them.
`timescale 1ns / 1ps
module seven_segment_display_frame_builder_checker import ssdfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  start_address,
  input  logic [15:0] shown_value,
  input  logic [2:0]  display_kind,
  input  logic        strobe,
  input  logic [7:0]  out_byte,
  input  logic        frame_begin,
  input  logic        frame_end,
  input  logic        digit_overflow,
  input  logic        last_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          words_pending,
  output int          words_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       fbegin;
    logic       fend;
    logic       ovf;
    logic       last;
  } frame_word_t;

  // digits 0..9, blank, C, H, decimal point
  localparam logic [7:0] GLYPHS [14] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
    8'h00, 8'h39, 8'h76, 8'h80
  };

  frame_word_t awaited_words[$];
  logic [7:0]  mode_cmd_copy;
  logic [7:0]  ctrl_cmd_copy;

  // Queue the seven words of one display update.
  function automatic void predict_update(input logic [7:0] addr, input logic [15:0] value,
                                         input logic [2:0] kind);
    int unsigned v;
    int unsigned digit [4];
    frame_word_t w;
    v = value;
    case (kind)
      KIND_TEMP:              digit[3] = IDX_C;
      KIND_HUMID:             digit[3] = IDX_H;
      KIND_LIGHT, KIND_PLAIN: digit[3] = v % 10;
      default:                digit[3] = IDX_BLANK;
    endcase
    if (v > 1000) begin
      digit[0] = v / 1000;
      digit[1] = (v / 100) % 10;
      digit[2] = (v / 10) % 10;
    end else if (v > 9) begin
      digit[0] = v / 10;
      digit[1] = v % 10;
      digit[2] = IDX_BLANK;
    end else begin
      digit[0] = 0;
      digit[1] = v;
      digit[2] = IDX_BLANK;
    end
    awaited_words.push_back('{mode_cmd_copy, 1'b1, 1'b1, 1'b0, 1'b0});
    awaited_words.push_back('{addr, 1'b1, 1'b0, 1'b0, 1'b0});
    for (int i = 0; i < 4; i++) begin
      w.ovf    = digit[i] >= TABLE_SIZE;
      w.data   = w.ovf ? 8'h00 : GLYPHS[digit[i]];
      w.fbegin = 1'b0;
      w.fend   = (i == 3);
      w.last   = 1'b0;
      awaited_words.push_back(w);
    end
    awaited_words.push_back('{ctrl_cmd_copy, 1'b1, 1'b1, 1'b0, 1'b1});
  endfunction

  always @(posedge clk) begin : watch
    frame_word_t want;
    if (rst) begin
      awaited_words.delete();
      mode_cmd_copy = DATA_MODE_RESET;
      ctrl_cmd_copy = DISP_CTRL_RESET;
      fail_count    = 0;
      words_checked = 0;
    end else begin
      if (strobe) begin
        if (awaited_words.size() == 0) begin
          $error("word %02h arrived with nothing expected", out_byte);
          fail_count++;
        end else begin
          want = awaited_words.pop_front();
          words_checked++;
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            fail_count++;
          end
          if (frame_begin !== want.fbegin) begin
            $error("frame_begin: expected %0b, got %0b", want.fbegin, frame_begin);
            fail_count++;
          end
          if (frame_end !== want.fend) begin
            $error("frame_end: expected %0b, got %0b", want.fend, frame_end);
            fail_count++;
          end
          if (digit_overflow !== want.ovf) begin
            $error("digit_overflow: expected %0b, got %0b", want.ovf, digit_overflow);
            fail_count++;
          end
          if (last_byte !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, last_byte);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DATA_MODE) mode_cmd_copy = pwdata[7:0];
        else                           ctrl_cmd_copy = pwdata[7:0];
      end
      if (start && !busy) predict_update(start_address, shown_value, display_kind);
    end
    words_pending = awaited_words.size();
  end

endmodule

// ===== tb/seven_segment_display_frame_builder_test.sv =====
// Top of the display frame builder testbench: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module seven_segment_display_frame_builder_test;
  import ssdfb_pkg::*;

  // No accept of any kind within the watchdog limit ends the run. Longest
  // correct quiet stretch is the longest sender gap or a drain pause, far below it.
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int RANDOM_PER_SETTING = 82;
  localparam int DIRECTED_COUNT     = 18;

  // Directed requests: digit-rule boundaries, table overflow on the first
  // digit (three-digit range from 140 up to 1000, four-digit range from
  // 14000), every kind including the unknown ones, address extremes.
  localparam logic [7:0] DIR_ADDR [DIRECTED_COUNT] = '{
    8'h00, 8'hff, 8'hc0, 8'h5a, 8'ha5, 8'h01, 8'h02, 8'h03, 8'h04,
    8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'hff
  };
  localparam logic [15:0] DIR_VALUE [DIRECTED_COUNT] = '{
    16'd0, 16'd9, 16'd10, 16'd99, 16'd139, 16'd140, 16'd1000, 16'd1001, 16'd9999,
    16'd13999, 16'd14000, 16'd65535, 16'd12345, 16'd7, 16'd500, 16'd4321,
    16'd65535, 16'd0
  };
  localparam logic [2:0] DIR_KIND [DIRECTED_COUNT] = '{
    KIND_PLAIN, KIND_TEMP, KIND_HUMID, KIND_LIGHT, KIND_PLAIN, KIND_PLAIN,
    KIND_LIGHT, KIND_TEMP, KIND_HUMID, KIND_LIGHT, KIND_PLAIN, KIND_TEMP,
    3'd0, 3'd5, 3'd6, 3'd7, KIND_LIGHT, 3'd0
  };

  // Register settings after the reset phase; the last one is drawn at random.
  localparam logic [7:0] MODE_SETTINGS [3] = '{8'h44, 8'h00, 8'hff};
  localparam logic [7:0] CTRL_SETTINGS [3] = '{8'h80, 8'h00, 8'hff};

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  start_address;
  logic [15:0] shown_value;
  logic [2:0]  display_kind;
  logic        strobe;
  logic [7:0]  out_byte;
  logic        frame_begin;
  logic        frame_end;
  logic        digit_overflow;
  logic        last_byte;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int words_pending;
  int words_checked;
  int requests_sent;
  int settings_run;
  int quiet_cycles;
  int burst_left;

  seven_segment_display_frame_builder dut (
    .clk, .rst, .start, .busy, .start_address, .shown_value, .display_kind,
    .strobe, .out_byte, .frame_begin, .frame_end, .digit_overflow, .last_byte,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  seven_segment_display_frame_builder_checker checker_i (
    .clk, .rst, .start, .busy, .start_address, .shown_value, .display_kind,
    .strobe, .out_byte, .frame_begin, .frame_end, .digit_overflow, .last_byte,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .words_pending, .words_checked
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Watchdog: counts cycles in which no request, word or register write is taken.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || strobe || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles, %0d words outstanding",
               WATCHDOG_LIMIT, words_pending);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the accept,
  // with start still high so a following request can go back to back.
  task automatic send_request(input logic [7:0] addr, input logic [15:0] value,
                              input logic [2:0] kind);
    start_address <= addr;
    shown_value   <= value;
    display_kind  <= kind;
    start         <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Sender idles for the given number of cycles (always nonzero).
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Sender stops until every predicted word has come out, then lets the
  // pipeline settle so a register write lands on an idle block.
  task automatic drain_updates();
    start <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (8) @(negedge clk);
  endtask

  // APB write with setup and access phases; upper data bits are noise the block must ignore.
  task automatic write_register(input logic reg_index, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Spread values over every digit-rule range, overflow ranges included.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 9));
      1:       return 16'($urandom_range(10, 139));
      2:       return 16'($urandom_range(140, 1000));
      3:       return 16'($urandom_range(1001, 13999));
      4:       return 16'($urandom_range(14000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random sender pacing: mostly back to back or short gaps, a few long
  // ones, occasional gap-free bursts and occasional full drains.
  task automatic pace_sender();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3)       drain_updates();
      else if (roll < 6)  burst_left = $urandom_range(15, 40);
      else if (roll < 50) burst_left = 0;
      else if (roll < 85) hold_off($urandom_range(1, 3));
      else if (roll < 97) hold_off($urandom_range(4, 12));
      else                hold_off($urandom_range(20, 60));
    end
  endtask

  task automatic random_requests(input int count);
    repeat (count) begin
      send_request(8'($urandom), pick_value(), 3'($urandom_range(0, 7)));
      pace_sender();
    end
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    start_address = '0;
    shown_value   = '0;
    display_kind  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    requests_sent = 0;
    burst_left    = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset register values: directed words back to back, then random.
    for (int i = 0; i < DIRECTED_COUNT; i++)
      send_request(DIR_ADDR[i], DIR_VALUE[i], DIR_KIND[i]);
    random_requests(RANDOM_PER_SETTING);
    settings_run = 1;

    // Further settings: a fixed one, then the extremes, then a random one; each change waits for an idle block.
    for (int s = 0; s < 4; s++) begin
      drain_updates();
      if (s < 3) begin
        write_register(REG_DATA_MODE, MODE_SETTINGS[s]);
        write_register(REG_DISP_CTRL, CTRL_SETTINGS[s]);
      end else begin
        write_register(REG_DATA_MODE, 8'($urandom));
        write_register(REG_DISP_CTRL, 8'($urandom));
      end
      random_requests(RANDOM_PER_SETTING);
      settings_run++;
    end

    // Let the last update finish, then a short tail to catch stray words.
    drain_updates();
    repeat (20) @(negedge clk);

    $display("Sent %0d display requests over %0d register settings, %0d words compared.",
             requests_sent, settings_run, words_checked);
    if (fail_count == 0 && words_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words never arrived", fail_count, words_pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ssdfb_pkg.sv
src/ssdfb_front.sv
src/ssdfb_queue.sv
src/ssdfb_back.sv
src/seven_segment_display_frame_builder.sv
tb/seven_segment_display_frame_builder_checker.sv
tb/seven_segment_display_frame_builder_test.sv
